// File: design/sliding_window_tangent_fit_core_defines.svh
// Assertion macros shared by the tangent fit checker
`ifndef SLIDING_WINDOW_TANGENT_FIT_CORE_DEFINES_SVH
`define SLIDING_WINDOW_TANGENT_FIT_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted
`define SWTF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted
`define SWTF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset
`define SWTF_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/swtf_pkg.sv
// Shared constants and transaction types of the sliding window tangent fit
package swtf_pkg;

    localparam int TIME_BITS      = 32;
    localparam int VALUE_BITS     = 24;
    localparam int MAX_HALF_DEF   = 16;
    localparam int HALF_BITS      = 5;
    localparam logic [HALF_BITS-1:0] HALF_RESET = 5'd2;
    localparam int CENTER_BITS    = 32;
    localparam int FIT_VALUE_BITS = 48;
    localparam int FIT_SLOPE_BITS = 64;
    localparam int VALUE_FRAC     = 16;
    localparam int SLOPE_FRAC     = 32;
    localparam int MUL_DIGIT      = 8;

    typedef struct packed {
        logic [TIME_BITS-1:0]         sample_time;
        logic signed [VALUE_BITS-1:0] sample_value;
        logic                         series_start;
    } in_item_t;

    typedef struct packed {
        logic [CENTER_BITS-1:0]           center_time;
        logic signed [FIT_VALUE_BITS-1:0] fitted_value;
        logic signed [FIT_SLOPE_BITS-1:0] fitted_slope;
        logic                             singular;
    } out_item_t;

endpackage

// File: design/swtf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data
module swtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem_reg[raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/swtf_mul.sv
// Sequential signed multiplier, one multiplier digit per cycle
module swtf_mul #(
    parameter int A_W = 16,
    parameter int B_W = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [A_W-1:0]   a,
    input  logic signed [B_W-1:0]   b,
    output logic                    done,
    output logic signed [A_W+B_W-1:0] prod
);

    localparam int DIG    = swtf_pkg::MUL_DIGIT;
    localparam int STEPS  = (B_W + DIG - 1) / DIG;
    localparam int BS_W   = STEPS * DIG;
    localparam int P_W    = A_W + B_W;
    localparam int STEP_W = $clog2(STEPS + 1);

    logic              busy_reg;
    logic              fix_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [STEP_W-1:0] step_reg;
    logic [P_W-1:0]    a_sh_reg;
    logic [BS_W-1:0]   b_sh_reg;
    logic [P_W-1:0]    acc_reg;
    logic [A_W-1:0]    a_mag;
    logic [B_W-1:0]    b_mag;
    logic [P_W-1:0]    part;

    // operand magnitudes
    assign a_mag = a[A_W-1] ? A_W'(-a) : A_W'(a);
    assign b_mag = b[B_W-1] ? B_W'(-b) : B_W'(b);

    // one digit partial product
    assign part = a_sh_reg * P_W'(b_sh_reg[DIG-1:0]);

    // control: run the digits, then fix the sign
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    fix_reg  <= 1'b1;
                end
            end else if (fix_reg) begin
                fix_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath: shift and accumulate
    always_ff @(posedge aclk) begin
        if (start) begin
            a_sh_reg <= P_W'(a_mag);
            b_sh_reg <= BS_W'(b_mag);
            acc_reg  <= '0;
            neg_reg  <= a[A_W-1] ^ b[B_W-1];
        end else if (busy_reg) begin
            acc_reg  <= acc_reg + part;
            a_sh_reg <= a_sh_reg << DIG;
            b_sh_reg <= b_sh_reg >> DIG;
        end else if (fix_reg) begin
            acc_reg <= neg_reg ? -acc_reg : acc_reg;
        end
    end

    assign done = done_reg;
    assign prod = $signed(acc_reg);

endmodule

// File: design/swtf_div.sv
// Restoring divider, one quotient bit per cycle, rounded and saturated
module swtf_div #(
    parameter int N_W   = 32,
    parameter int D_W   = 16,
    parameter int OUT_W = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [N_W-1:0]   num,
    input  logic [D_W-1:0]          den,
    output logic                    done,
    output logic signed [OUT_W-1:0] quot
);

    localparam int CNT_W = $clog2(N_W + 1);
    localparam int C_W   = ((N_W + 1 > OUT_W) ? N_W + 1 : OUT_W) + 1;

    logic             run_reg;
    logic             rnd_reg;
    logic             sat_reg;
    logic             done_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [N_W-1:0]   m_reg;
    logic [N_W-1:0]   q_reg;
    logic [D_W-1:0]   r_reg;
    logic [D_W-1:0]   den_reg;
    logic [N_W:0]     qr_reg;
    logic [OUT_W-1:0] quot_reg;
    logic [D_W:0]     r_try;
    logic             r_ge;
    logic             rnd_up;
    logic [C_W-1:0]   mag;
    logic [C_W-1:0]   lim_pos;
    logic [C_W-1:0]   lim_neg;
    logic [C_W-1:0]   sat_val;

    // trial subtraction
    assign r_try  = {r_reg, m_reg[N_W-1]};
    assign r_ge   = r_try >= {1'b0, den_reg};
    assign rnd_up = {r_reg, 1'b0} >= {1'b0, den_reg};

    // clamp the rounded magnitude to the output range
    always_comb begin
        mag     = C_W'(qr_reg);
        lim_pos = (C_W'(1) << (OUT_W - 1)) - C_W'(1);
        lim_neg = C_W'(1) << (OUT_W - 1);
        if (!neg_reg) begin
            sat_val = (mag > lim_pos) ? lim_pos : mag;
        end else begin
            sat_val = (mag > lim_neg) ? -lim_neg : -mag;
        end
    end

    // control: divide, round, saturate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            rnd_reg  <= 1'b0;
            sat_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(N_W - 1)) begin
                    run_reg <= 1'b0;
                    rnd_reg <= 1'b1;
                end
            end else if (rnd_reg) begin
                rnd_reg <= 1'b0;
                sat_reg <= 1'b1;
            end else if (sat_reg) begin
                sat_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= num[N_W-1];
            m_reg   <= num[N_W-1] ? N_W'(-num) : N_W'(num);
            den_reg <= den;
            r_reg   <= '0;
            q_reg   <= '0;
        end else if (run_reg) begin
            r_reg <= r_ge ? D_W'(r_try - {1'b0, den_reg}) : D_W'(r_try);
            q_reg <= {q_reg[N_W-2:0], r_ge};
            m_reg <= m_reg << 1;
        end else if (rnd_reg) begin
            qr_reg <= {1'b0, q_reg} + (N_W+1)'(rnd_up);
        end else if (sat_reg) begin
            quot_reg <= sat_val[OUT_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = $signed(quot_reg);

endmodule

// File: design/sliding_window_tangent_fit_core.sv
// Sliding window tangent fit: top level with sample ring, walk and fit sequencer
//
// Usage:
//   s_valid/s_ready/s_data carry one timestamped sample per transaction.
//   m_valid/m_ready/m_data carry one fit result: centre time, fitted value
//   (16 fraction bits), slope (32 fraction bits) and a singular flag.
//   cfg_valid/cfg_ready/cfg_data write the half width H (window 2H+1);
//   cfg_ready is always high. Write it only while the block is idle.
// Timing:
//   A sample that leaves the window short of 2H+1 points starts no fit.
//   A sample that completes a window holds s_ready low while its fit runs:
//   the ring memory is walked one entry per cycle, six products are formed
//   on one digit-serial multiplier and the two quotients come from bit-serial
//   dividers running side by side (skipped for a singular fit).
//   s_ready is high only while the sequencer is idle.
// Reset and stall:
//   Reset empties the window, sets H to 2 and drops any pending result.
//   A finished result waits in the output register; the next sample is still
//   taken, but the sequencer holds before its own result until m_ready.
module sliding_window_tangent_fit_core #(
    parameter int MAX_HALF = swtf_pkg::MAX_HALF_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  swtf_pkg::in_item_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output swtf_pkg::out_item_t            m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [swtf_pkg::HALF_BITS-1:0] cfg_data
);

    localparam int DEPTH  = 2 * MAX_HALF + 1;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int TB     = swtf_pkg::TIME_BITS;
    localparam int VB     = swtf_pkg::VALUE_BITS;
    localparam int E_W    = TB + VB;
    localparam int DT_W   = TB + 1;
    localparam int TV_W   = DT_W + VB;
    localparam int S1_W   = DT_W + CNT_W;
    localparam int S2_W   = 2 * TB + CNT_W + 1;
    localparam int SY_W   = VB + CNT_W;
    localparam int STY_W  = TV_W + CNT_W;
    localparam int A_W0   = (S2_W > STY_W) ? S2_W : STY_W;
    localparam int A_W    = (A_W0 > S1_W) ? A_W0 : S1_W;
    localparam int B_W    = (S1_W > SY_W) ? S1_W : SY_W;
    localparam int P_W    = A_W + B_W;
    localparam int NUM_W  = P_W + 1 + swtf_pkg::SLOPE_FRAC;
    localparam logic [2:0] MSTEP_LAST = 3'd5;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_CTR   = 10'b00_0000_0010,
        ST_TC    = 10'b00_0000_0100,
        ST_WALK  = 10'b00_0000_1000,
        ST_MUL   = 10'b00_0001_0000,
        ST_MWAIT = 10'b00_0010_0000,
        ST_DET   = 10'b00_0100_0000,
        ST_DIV   = 10'b00_1000_0000,
        ST_DWAIT = 10'b01_0000_0000,
        ST_OUT   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [swtf_pkg::HALF_BITS-1:0] hw_reg;
    logic [IDX_W-1:0]  wp_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  h_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  iss_reg;
    logic              p1_reg, p2_reg, p3_reg;
    logic [2:0]        mstep_reg;
    logic              sing_reg;
    logic              m_valid_reg;
    swtf_pkg::out_item_t m_data_reg;

    logic [TB-1:0]            tc_reg;
    logic signed [DT_W-1:0]   dt_reg, dt3_reg;
    logic signed [VB-1:0]     v2_reg, v3_reg;
    logic [2*TB-1:0]          sq_reg;
    logic signed [TV_W-1:0]   tv_reg;
    logic signed [S1_W-1:0]   s1_reg;
    logic signed [S2_W-1:0]   s2_reg;
    logic signed [SY_W-1:0]   sy_reg;
    logic signed [STY_W-1:0]  sty_reg;
    logic signed [P_W-1:0]    p_reg [6];
    logic [P_W-1:0]           den_reg;
    logic signed [NUM_W-1:0]  numa_reg, numb_reg;

    logic              accept;
    logic [7:0]        hw_ext, h_sel;
    logic [CNT_W-1:0]  h_cur, n_cur;
    logic [IDX_W-1:0]  wp_inc;
    logic [CNT_W-1:0]  fill_base, fill_new;
    logic [CNT_W:0]    st_sum, st_fold, c_sum, c_fold;
    logic [IDX_W-1:0]  start_idx, cidx, idx_inc, raddr;
    logic              issue;
    logic              out_free;
    logic [E_W-1:0]    rd_data;
    logic [TB-1:0]     rd_t;
    logic signed [VB-1:0] rd_v;
    logic [TB-1:0]     adt;
    logic signed [A_W-1:0] mul_a;
    logic signed [B_W-1:0] mul_b;
    logic signed [CNT_W:0] n_sgn;
    logic              mul_start, mul_done;
    logic signed [P_W-1:0] mul_prod;
    logic signed [P_W:0] det_full, diff_a, diff_b;
    logic              det_zero;
    logic              div_start, diva_done, divb_done;
    logic signed [swtf_pkg::FIT_VALUE_BITS-1:0] quot_a;
    logic signed [swtf_pkg::FIT_SLOPE_BITS-1:0] quot_b;
    swtf_pkg::out_item_t out_next;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    // clamp the half width to 1..MAX_HALF
    always_comb begin
        hw_ext = 8'(hw_reg);
        if (hw_ext == 8'd0) begin
            h_sel = 8'd1;
        end else if (hw_ext > 8'(MAX_HALF)) begin
            h_sel = 8'(MAX_HALF);
        end else begin
            h_sel = hw_ext;
        end
    end

    assign h_cur = CNT_W'(h_sel);
    assign n_cur = CNT_W'({h_sel, 1'b1});

    // ring pointer and fill bookkeeping for the incoming sample
    assign wp_inc    = (wp_reg == IDX_W'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign fill_base = s_data.series_start ? '0 : fill_reg;
    assign fill_new  = (fill_base < CNT_W'(DEPTH)) ? fill_base + 1'b1 : fill_base;

    // oldest window entry and window centre, folded into the ring
    always_comb begin
        st_sum  = (CNT_W+1)'(wp_inc) + (CNT_W+1)'(DEPTH) - (CNT_W+1)'(n_cur);
        st_fold = (st_sum >= (CNT_W+1)'(DEPTH)) ? st_sum - (CNT_W+1)'(DEPTH) : st_sum;
        c_sum   = (CNT_W+1)'(idx_reg) + (CNT_W+1)'(h_reg);
        c_fold  = (c_sum >= (CNT_W+1)'(DEPTH)) ? c_sum - (CNT_W+1)'(DEPTH) : c_sum;
    end

    assign start_idx = IDX_W'(st_fold);
    assign cidx      = IDX_W'(c_fold);
    assign idx_inc   = (idx_reg == IDX_W'(DEPTH - 1)) ? '0 : idx_reg + 1'b1;
    assign raddr     = (state_reg == ST_CTR) ? cidx : idx_reg;
    assign issue     = (state_reg == ST_TC) ||
                       ((state_reg == ST_WALK) && (iss_reg < n_reg));

    // sample ring: time stamp above value
    swtf_ram #(
        .WIDTH (E_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .we      (accept),
        .waddr   (wp_reg),
        .wdata   ({s_data.sample_time, s_data.sample_value}),
        .raddr   (raddr),
        .rd_data (rd_data)
    );

    assign rd_t = rd_data[E_W-1:VB];
    assign rd_v = $signed(rd_data[VB-1:0]);
    assign adt  = dt_reg[DT_W-1] ? TB'(-dt_reg) : TB'(dt_reg);

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (fill_new >= n_cur)) begin
                    state_next = ST_CTR;
                end
            end
            ST_CTR:  state_next = ST_TC;
            ST_TC:   state_next = ST_WALK;
            ST_WALK: begin
                if (!issue && !p1_reg && !p2_reg && !p3_reg) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_MWAIT;
            ST_MWAIT: begin
                if (mul_done) begin
                    state_next = (mstep_reg == MSTEP_LAST) ? ST_DET : ST_MUL;
                end
            end
            ST_DET:  state_next = det_zero ? ST_OUT : ST_DIV;
            ST_DIV:  state_next = ST_DWAIT;
            ST_DWAIT: begin
                if (diva_done && divb_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            hw_reg      <= swtf_pkg::HALF_RESET;
            wp_reg      <= '0;
            fill_reg    <= '0;
            iss_reg     <= '0;
            p1_reg      <= 1'b0;
            p2_reg      <= 1'b0;
            p3_reg      <= 1'b0;
            mstep_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            p1_reg    <= issue;
            p2_reg    <= p1_reg;
            p3_reg    <= p2_reg;
            if (cfg_valid) begin
                hw_reg <= cfg_data;
            end
            if (accept) begin
                wp_reg   <= wp_inc;
                fill_reg <= fill_new;
            end
            if (state_reg == ST_TC) begin
                iss_reg <= CNT_W'(1);
            end else if (issue) begin
                iss_reg <= iss_reg + 1'b1;
            end
            if (state_reg == ST_WALK) begin
                mstep_reg <= '0;
            end else if ((state_reg == ST_MWAIT) && mul_done) begin
                mstep_reg <= mstep_reg + 1'b1;
            end
            if ((state_reg == ST_OUT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // window walk: difference, products, sums
    always_ff @(posedge aclk) begin
        if (accept) begin
            h_reg   <= h_cur;
            n_reg   <= n_cur;
            idx_reg <= start_idx;
        end else if (issue) begin
            idx_reg <= idx_inc;
        end
        dt_reg  <= $signed({1'b0, rd_t}) - $signed({1'b0, tc_reg});
        v2_reg  <= rd_v;
        sq_reg  <= adt * adt;
        tv_reg  <= dt_reg * v2_reg;
        dt3_reg <= dt_reg;
        v3_reg  <= v2_reg;
        if (state_reg == ST_TC) begin
            tc_reg  <= rd_t;
            s1_reg  <= '0;
            s2_reg  <= '0;
            sy_reg  <= '0;
            sty_reg <= '0;
        end else if (p3_reg) begin
            s1_reg  <= s1_reg + S1_W'(dt3_reg);
            s2_reg  <= s2_reg + S2_W'(sq_reg);
            sy_reg  <= sy_reg + SY_W'(v3_reg);
            sty_reg <= sty_reg + STY_W'(tv_reg);
        end
    end

    // multiplier operands per product step
    assign n_sgn = $signed({1'b0, n_reg});

    always_comb begin
        unique case (mstep_reg)
            3'd0: begin mul_a = A_W'(s2_reg);  mul_b = B_W'(n_sgn);  end
            3'd1: begin mul_a = A_W'(s1_reg);  mul_b = B_W'(s1_reg); end
            3'd2: begin mul_a = A_W'(s2_reg);  mul_b = B_W'(sy_reg); end
            3'd3: begin mul_a = A_W'(sty_reg); mul_b = B_W'(s1_reg); end
            3'd4: begin mul_a = A_W'(sty_reg); mul_b = B_W'(n_sgn);  end
            3'd5: begin mul_a = A_W'(s1_reg);  mul_b = B_W'(sy_reg); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_start = (state_reg == ST_MUL);

    swtf_mul #(
        .A_W (A_W),
        .B_W (B_W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    // determinant and numerators
    assign det_full = (P_W+1)'(p_reg[0]) - (P_W+1)'(p_reg[1]);
    assign diff_a   = (P_W+1)'(p_reg[2]) - (P_W+1)'(p_reg[3]);
    assign diff_b   = (P_W+1)'(p_reg[4]) - (P_W+1)'(p_reg[5]);
    assign det_zero = (det_full == '0);

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_MWAIT) && mul_done) begin
            p_reg[mstep_reg] <= mul_prod;
        end
        if (state_reg == ST_DET) begin
            den_reg  <= P_W'(det_full);
            numa_reg <= NUM_W'(diff_a) <<< swtf_pkg::VALUE_FRAC;
            numb_reg <= NUM_W'(diff_b) <<< swtf_pkg::SLOPE_FRAC;
            sing_reg <= det_zero;
        end
    end

    assign div_start = (state_reg == ST_DIV);

    swtf_div #(
        .N_W   (NUM_W),
        .D_W   (P_W),
        .OUT_W (swtf_pkg::FIT_VALUE_BITS)
    ) u_div_value (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (numa_reg),
        .den     (den_reg),
        .done    (diva_done),
        .quot    (quot_a)
    );

    swtf_div #(
        .N_W   (NUM_W),
        .D_W   (P_W),
        .OUT_W (swtf_pkg::FIT_SLOPE_BITS)
    ) u_div_slope (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (numb_reg),
        .den     (den_reg),
        .done    (divb_done),
        .quot    (quot_b)
    );

    // result transaction
    always_comb begin
        out_next.center_time  = swtf_pkg::CENTER_BITS'(tc_reg);
        out_next.fitted_value = sing_reg ? '0 : quot_a;
        out_next.fitted_slope = sing_reg ? '0 : quot_b;
        out_next.singular     = sing_reg;
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_OUT) && out_free) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: design/swtf_checker.sv
// Port-level assertions for the tangent fit core, bound to the top level
`include "sliding_window_tangent_fit_core_defines.svh"

module swtf_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input swtf_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input swtf_pkg::out_item_t m_data
);

    // a stalled result holds
    `SWTF_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    // reset drops any pending result
    `SWTF_ASSERT_RST(a_reset_empty, !aresetn, !m_valid, "result valid after reset")

    // a series start can never complete a window, so the block is free again at once
    `SWTF_ASSERT_NEXT(a_start_no_fit, s_valid && s_ready && s_data.series_start, s_ready, "busy after series start")

    // a singular fit carries zero value and slope
    `SWTF_ASSERT_SAME(a_singular_zero, m_valid && m_data.singular, (m_data.fitted_value == '0) && (m_data.fitted_slope == '0), "singular result not zero")

endmodule

bind sliding_window_tangent_fit_core swtf_checker u_swtf_checker (.*);
